### src/fdes_pkg.sv
`timescale 1ns / 1ps

package fdes_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int ENTRY_BYTES = 32;
	localparam int ENTRIES_PER_SECTOR = SECTOR_BYTES / ENTRY_BYTES;
	localparam int IDX_W = $clog2(ENTRIES_PER_SECTOR);
	localparam int ENTRY_SHIFT = $clog2(ENTRY_BYTES);

	localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
	localparam logic [7:0] NAME_DOT = 8'h2E;
	localparam logic [7:0] NAME_END = 8'h00;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_ENTRY = 1'b1;

	localparam logic CFG_CLUSTER_SIZE = 1'b0;
	localparam logic CFG_DATA_START_SECTOR = 1'b1;

	typedef enum logic [1:0] {
		ST_READ_SECTOR = 2'd0,
		ST_FOUND = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NOT_DIR = 2'd3
	} status_t;

	typedef struct packed {
		logic mode;
		logic [63:0] name_field;
		logic [23:0] ext_field;
		logic [7:0] attr_field;
		logic [15:0] first_cluster;
		logic [31:0] file_size;
		logic [31:0] dir_sector;
		logic [31:0] dir_length;
	} fdes_in_t;

	typedef struct packed {
		status_t status;
		logic [31:0] sector_number;
		logic [8:0] entry_offset;
		logic [7:0] found_attr;
		logic [31:0] found_size;
		logic [31:0] data_sector;
	} fdes_out_t;

endpackage

### src/fat_directory_entry_search_top.sv
`timescale 1ns / 1ps
// A request is held in in_s1 and its result in res_s2. Throughput: one request
// per cycle unless the output stalls; the input register and the result register
// let a new request enter while a finished result still waits at the output.
// The per-entry compare and the cluster-to-sector multiply-add sit between them.
// Reset (arst_n low, asynchronous) clears the search state and both valid flags
// and sets the cluster size register to 1 and data_start_sector to 0.
module fat_directory_entry_search_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fdes_pkg::fdes_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output fdes_pkg::fdes_out_t out_data,
	input logic cfg_we,
	input logic cfg_addr,
	input logic [31:0] cfg_wdata
);
	import fdes_pkg::*;

	logic [7:0] spc_q;
	logic [31:0] data_start_q;

	logic searching_q;
	logic [31:0] cur_sector_q;
	logic [31:0] remaining_q;
	logic [IDX_W-1:0] idx_q;
	logic ended_q;
	logic [63:0] target_name_q;
	logic [23:0] target_ext_q;

	fdes_in_t in_s1;
	logic in_valid_s1;
	fdes_out_t res_s2;
	logic res_valid_s2;

	logic adv_s1;
	logic res_valid;
	fdes_out_t res;

	logic searching_d;
	logic [31:0] cur_sector_d;
	logic [31:0] remaining_d;
	logic [IDX_W-1:0] idx_d;
	logic ended_d;

	logic [IDX_W+ENTRY_SHIFT:0] entry_end;
	logic in_range;
	logic name_match;
	logic [23:0] cluster_prod;
	logic [31:0] data_sector;

	assign adv_s1 = in_valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || adv_s1;
	assign out_valid = res_valid_s2;
	assign out_data = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= 8'd1;
			data_start_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CLUSTER_SIZE: spc_q <= cfg_wdata[7:0];
				CFG_DATA_START_SECTOR: data_start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The end of the entry has to fit inside the bytes left in the directory.
	assign entry_end = (IDX_W+ENTRY_SHIFT+1)'({idx_q, {ENTRY_SHIFT{1'b0}}})
		+ (IDX_W+ENTRY_SHIFT+1)'(ENTRY_BYTES);
	assign in_range = !ended_q && (32'(entry_end) <= remaining_q);
	assign name_match = (in_s1.name_field == target_name_q)
		&& (in_s1.ext_field == target_ext_q);

	// Cluster size times (cluster - 2) modulo 2^32, folded into one product.
	assign cluster_prod = spc_q * in_s1.first_cluster;
	assign data_sector = data_start_q + {8'd0, cluster_prod} - {23'd0, spc_q, 1'b0};

	always_comb begin
		searching_d = searching_q;
		cur_sector_d = cur_sector_q;
		remaining_d = remaining_q;
		idx_d = idx_q;
		ended_d = ended_q;
		res_valid = 1'b0;
		res = '0;
		res.status = ST_READ_SECTOR;
		if (in_s1.mode == MODE_START) begin
			res_valid = 1'b1;
			if ((in_s1.attr_field & ATTR_DIRECTORY) == 8'd0) begin
				searching_d = 1'b0;
				res.status = ST_NOT_DIR;
			end else begin
				searching_d = 1'b1;
				cur_sector_d = in_s1.dir_sector;
				remaining_d = in_s1.dir_length;
				idx_d = '0;
				ended_d = 1'b0;
				res.status = ST_READ_SECTOR;
				res.sector_number = in_s1.dir_sector;
			end
		end else if (searching_q) begin
			if (in_range && in_s1.name_field[7:0] == NAME_END) begin
				ended_d = 1'b1;
			end
			if (in_range && in_s1.name_field[7:0] != NAME_END
					&& in_s1.name_field[7:0] != NAME_DOT && name_match) begin
				res_valid = 1'b1;
				searching_d = 1'b0;
				res.status = ST_FOUND;
				res.sector_number = cur_sector_q;
				res.entry_offset = 9'({idx_q, {ENTRY_SHIFT{1'b0}}});
				res.found_attr = in_s1.attr_field;
				res.found_size = in_s1.file_size;
				res.data_sector = data_sector;
			end else if (idx_q == IDX_W'(ENTRIES_PER_SECTOR - 1)) begin
				res_valid = 1'b1;
				if (remaining_q >= 32'(SECTOR_BYTES)) begin
					cur_sector_d = cur_sector_q + 32'd1;
					remaining_d = remaining_q - 32'(SECTOR_BYTES);
					idx_d = '0;
					ended_d = 1'b0;
					res.status = ST_READ_SECTOR;
					res.sector_number = cur_sector_q + 32'd1;
				end else begin
					searching_d = 1'b0;
					res.status = ST_NOT_FOUND;
				end
			end else begin
				idx_d = idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
			searching_q <= 1'b0;
			cur_sector_q <= 32'd0;
			remaining_q <= 32'd0;
			idx_q <= '0;
			ended_q <= 1'b0;
			target_name_q <= 64'd0;
			target_ext_q <= 24'd0;
		end else begin
			if (in_valid && in_ready) begin
				in_valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				in_valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_s2 <= res_valid;
				searching_q <= searching_d;
				cur_sector_q <= cur_sector_d;
				remaining_q <= remaining_d;
				idx_q <= idx_d;
				ended_q <= ended_d;
				if (in_s1.mode == MODE_START) begin
					target_name_q <= in_s1.name_field;
					target_ext_q <= in_s1.ext_field;
				end
			end else if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (adv_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	// A match always sits on an entry boundary.
	a_found_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.status == ST_FOUND
			|-> res_s2.entry_offset[ENTRY_SHIFT-1:0] == '0)
		else $error("matched entry offset not aligned to an entry");

	// Only a match carries entry details.
	a_no_details: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.status != ST_FOUND
			|-> res_s2.entry_offset == '0 && res_s2.found_attr == '0
				&& res_s2.found_size == '0 && res_s2.data_sector == '0)
		else $error("entry details on a result that is not a match");

	// Terminal results carry no sector.
	a_terminal_sector: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && (res_s2.status == ST_NOT_FOUND || res_s2.status == ST_NOT_DIR)
			|-> res_s2.sector_number == '0)
		else $error("sector number on a terminal result");

	// Any result other than a sector request ends the search.
	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_valid && res.status != ST_READ_SECTOR |=> !searching_q)
		else $error("search still running after a terminal result");

	// A sector request always restarts at the first entry of a fresh sector.
	a_sector_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_valid && res.status == ST_READ_SECTOR
			|=> searching_q && idx_q == '0 && !ended_q)
		else $error("sector request without a fresh sector state");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fdes_pkg::*;

	// Mirrors the directory search and keeps the answers still owed by the block.
	class dir_search_scoreboard;
		logic [7:0] spc = 8'd1;
		logic [31:0] data_start = 32'd0;
		bit active = 1'b0;
		logic [31:0] cur_sector = '0;
		logic [31:0] bytes_left = '0;
		int unsigned slot = 0;
		bit sector_done = 1'b0;
		logic [63:0] want_name = '0;
		logic [23:0] want_ext = '0;
		fdes_out_t pending_answers[$];
		int errors = 0;

		function void set_register(logic addr, logic [31:0] value);
			if (addr == CFG_CLUSTER_SIZE) begin
				spc = value[7:0];
			end else begin
				data_start = value;
			end
		endfunction

		function bit lookup_step(fdes_in_t r, output fdes_out_t res);
			int unsigned limit;
			int unsigned span_end;
			res = '0;
			if (r.mode == MODE_START) begin
				want_name = r.name_field;
				want_ext = r.ext_field;
				if ((r.attr_field & ATTR_DIRECTORY) == 8'h00) begin
					active = 1'b0;
					res.status = ST_NOT_DIR;
					return 1'b1;
				end
				active = 1'b1;
				cur_sector = r.dir_sector;
				bytes_left = r.dir_length;
				slot = 0;
				sector_done = 1'b0;
				res.status = ST_READ_SECTOR;
				res.sector_number = cur_sector;
				return 1'b1;
			end
			if (!active) begin
				return 1'b0;
			end
			limit = (bytes_left < SECTOR_BYTES) ? bytes_left : SECTOR_BYTES;
			span_end = (slot + 1) * ENTRY_BYTES;
			if (!sector_done && span_end <= limit) begin
				if (r.name_field[7:0] == NAME_END) begin
					sector_done = 1'b1;
				end else if (r.name_field[7:0] != NAME_DOT && r.name_field == want_name
						&& r.ext_field == want_ext) begin
					res.status = ST_FOUND;
					res.sector_number = cur_sector;
					res.entry_offset = 9'(slot * ENTRY_BYTES);
					res.found_attr = r.attr_field;
					res.found_size = r.file_size;
					res.data_sector = data_start + 32'(spc) * (32'(r.first_cluster) - 32'd2);
					active = 1'b0;
					return 1'b1;
				end
			end
			if (slot == ENTRIES_PER_SECTOR - 1) begin
				if (bytes_left >= SECTOR_BYTES) begin
					cur_sector = cur_sector + 32'd1;
					bytes_left = bytes_left - SECTOR_BYTES;
					slot = 0;
					sector_done = 1'b0;
					res.status = ST_READ_SECTOR;
					res.sector_number = cur_sector;
				end else begin
					active = 1'b0;
					res.status = ST_NOT_FOUND;
				end
				return 1'b1;
			end
			slot = slot + 1;
			return 1'b0;
		endfunction

		function void note_request(fdes_in_t r);
			fdes_out_t res;
			if (lookup_step(r, res)) begin
				pending_answers.push_back(res);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("%0t ns: MISMATCH %s", $time, what);
		endtask

		task check_result(fdes_out_t got);
			fdes_out_t want;
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, status %0d", got.status));
				return;
			end
			want = pending_answers.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.sector_number !== want.sector_number)
				report_mismatch($sformatf("sector_number %h, expected %h",
					got.sector_number, want.sector_number));
			if (got.entry_offset !== want.entry_offset)
				report_mismatch($sformatf("entry_offset %0d, expected %0d",
					got.entry_offset, want.entry_offset));
			if (got.found_attr !== want.found_attr)
				report_mismatch($sformatf("found_attr %h, expected %h",
					got.found_attr, want.found_attr));
			if (got.found_size !== want.found_size)
				report_mismatch($sformatf("found_size %h, expected %h",
					got.found_size, want.found_size));
			if (got.data_sector !== want.data_sector)
				report_mismatch($sformatf("data_sector %h, expected %h",
					got.data_sector, want.data_sector));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	fdes_in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	fdes_out_t out_data;
	logic cfg_we;
	logic cfg_addr;
	logic [31:0] cfg_wdata;

	dir_search_scoreboard sb;
	int send_idle = 0;
	int stall_pct = 0;
	logic [63:0] gen_name;
	logic [23:0] gen_ext;

	fat_directory_entry_search_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(out_data);
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#10_000_000;
		$display("fat_directory_entry_search_top test failed");
		$finish;
	end

	function automatic fdes_in_t random_request();
		fdes_in_t r;
		r.mode = 1'($urandom_range(1));
		r.name_field = {$urandom, $urandom};
		r.ext_field = 24'($urandom);
		r.attr_field = 8'($urandom);
		r.first_cluster = 16'($urandom);
		r.file_size = $urandom;
		r.dir_sector = $urandom;
		r.dir_length = $urandom;
		return r;
	endfunction

	task automatic send_request(input fdes_in_t r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic send_start(input fdes_in_t r);
		r.mode = MODE_START;
		gen_name = r.name_field;
		gen_ext = r.ext_field;
		send_request(r);
	endtask

	task automatic start_search();
		fdes_in_t r;
		int unsigned shape;
		r = random_request();
		shape = $urandom_range(15);
		if (shape == 0) begin
			r.name_field[7:0] = NAME_DOT;
		end else if (shape == 1) begin
			r.name_field[7:0] = NAME_END;
		end
		if ($urandom_range(7) == 0) begin
			r.attr_field &= ~ATTR_DIRECTORY;
		end else begin
			r.attr_field |= ATTR_DIRECTORY;
		end
		// Mostly short directories so that sector ends and not-found answers come often.
		case ($urandom_range(7))
			0, 1, 2: r.dir_length = $urandom_range(511);
			3, 4: r.dir_length = $urandom_range(1535, 512);
			5: r.dir_length = SECTOR_BYTES * $urandom_range(3);
			6: r.dir_length = 32'hFFFF_FFFF - $urandom_range(31);
			default: ;
		endcase
		if ($urandom_range(7) == 0) begin
			r.dir_sector = 32'hFFFF_FFFF - $urandom_range(1);
		end
		send_start(r);
	endtask

	task automatic send_entry();
		fdes_in_t r;
		int unsigned pick;
		int unsigned flip;
		r = random_request();
		r.mode = MODE_ENTRY;
		pick = $urandom_range(31);
		if (pick < 3) begin
			r.name_field = gen_name;
			r.ext_field = gen_ext;
		end else if (pick == 3) begin
			r.name_field[7:0] = NAME_END;
		end else if (pick == 4) begin
			r.name_field[7:0] = NAME_DOT;
		end else if (pick < 7) begin
			// Near miss: the target with one bit of the name or extension flipped.
			r.name_field = gen_name;
			r.ext_field = gen_ext;
			flip = $urandom_range(87);
			if (flip < 64) begin
				r.name_field[flip] = ~r.name_field[flip];
			end else begin
				r.ext_field[flip - 64] = ~r.ext_field[flip - 64];
			end
		end
		send_request(r);
	endtask

	task automatic write_reg(input logic addr, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(addr, value);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_answers.size() != 0) begin
			@(posedge clk);
		end
		// Entries that produce no answer may still be in flight.
		repeat (4) @(posedge clk);
	endtask

	initial begin
		fdes_in_t r;
		int counted;
		int stage_no;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		gen_name = '0;
		gen_ext = '0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An entry with no search running is dropped.
		r = random_request();
		r.mode = MODE_ENTRY;
		send_request(r);

		// Start on something that is not a directory, all other fields at their maximum.
		r = '1;
		r.attr_field = ~ATTR_DIRECTORY;
		send_start(r);

		// A dot entry is skipped, then the target is found in the second slot.
		r = random_request();
		r.name_field[7:0] = 8'h41;
		r.attr_field = ATTR_DIRECTORY;
		r.dir_sector = 32'd100;
		r.dir_length = 32'd1024;
		send_start(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.name_field[7:0] = NAME_DOT;
		send_request(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.name_field = gen_name;
		r.ext_field = gen_ext;
		r.attr_field = '1;
		r.first_cluster = '0;
		r.file_size = '1;
		send_request(r);

		// A target that starts with a dot never matches, even exactly.
		r = random_request();
		r.name_field[7:0] = NAME_DOT;
		r.attr_field = '1;
		r.dir_sector = '1;
		r.dir_length = '1;
		send_start(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.name_field = gen_name;
		r.ext_field = gen_ext;
		send_request(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.first_cluster = 16'd1;
		send_request(r);

		// Restart while searching; an end marker hides the target, then not found.
		r = random_request();
		r.name_field[7:0] = 8'h5A;
		r.attr_field = ATTR_DIRECTORY;
		r.dir_sector = 32'd7;
		r.dir_length = 32'd40;
		send_start(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.name_field[7:0] = NAME_END;
		send_request(r);
		r = random_request();
		r.mode = MODE_ENTRY;
		r.name_field = gen_name;
		r.ext_field = gen_ext;
		send_request(r);
		repeat (ENTRIES_PER_SECTOR - 2) begin
			r = random_request();
			r.mode = MODE_ENTRY;
			send_request(r);
		end
		drain();

		for (stage_no = 0; stage_no < 4; stage_no++) begin
			case (stage_no)
				0: begin
					send_idle = 0;
					stall_pct = 0;
					write_reg(CFG_CLUSTER_SIZE, 32'd128);
					write_reg(CFG_DATA_START_SECTOR, 32'hFFFF_FFFF);
				end
				1: begin
					send_idle = 69;
					stall_pct = 0;
					write_reg(CFG_CLUSTER_SIZE, 32'd1);
					write_reg(CFG_DATA_START_SECTOR, 32'd0);
				end
				2: begin
					send_idle = 0;
					stall_pct = 69;
					write_reg(CFG_CLUSTER_SIZE, $urandom_range(128, 1));
					write_reg(CFG_DATA_START_SECTOR, $urandom);
				end
				default: begin
					send_idle = 29;
					stall_pct = 29;
					write_reg(CFG_CLUSTER_SIZE, $urandom_range(128, 1));
					write_reg(CFG_DATA_START_SECTOR, $urandom);
				end
			endcase
			cfg_we <= 1'b0;

			counted = 0;
			while (counted < 175) begin
				if (!sb.active) begin
					if ($urandom_range(9) == 0) begin
						r = random_request();
						r.mode = MODE_ENTRY;
						send_request(r);
					end else begin
						start_search();
						counted++;
					end
				end else begin
					if ($urandom_range(99) < 2) begin
						start_search();
					end else begin
						send_entry();
					end
					counted++;
				end
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("fat_directory_entry_search_top test passed");
		end else begin
			$display("fat_directory_entry_search_top test failed");
		end
		$finish;
	end

endmodule
